@@ design/shbs_pkg.sv @@
// Shared types, constants and a helper function for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package shbs_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [0:7] hvec_t;
	typedef word_t [0:15] block_t;

	localparam int unsigned CountBits = 61;
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenBytePos = 6'd56;
	localparam logic [5:0] LastBytePos = 6'd63;
	localparam logic [5:0] LastRound = 6'd63;

	localparam word_t InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// rotate right by a constant amount
	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

`default_nettype wire

@@ design/shbs_req_if.sv @@
// Request channel interface: one message byte or a finish request per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface shbs_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] message_byte;

	modport source (output valid, output req_type, output message_byte, input ready);
	modport sink (input valid, input req_type, input message_byte, output ready);
endinterface

`default_nettype wire

@@ design/shbs_dig_if.sv @@
// Digest channel interface: one 32-bit digest word per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface shbs_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

`default_nettype wire

@@ design/shbs_round.sv @@
// One SHA-256 round plus one step of the rolling message schedule.
`timescale 1ns / 1ps
`default_nettype none

module shbs_round (
	input  wire shbs_pkg::hvec_t  v,
	input  wire shbs_pkg::block_t win,
	input  wire shbs_pkg::word_t  kt,
	output shbs_pkg::hvec_t  v_nxt,
	output shbs_pkg::word_t  w_nxt
);

	shbs_pkg::word_t sig0, sig1, big0, big1, ch, maj, t1, t2;

	// schedule: win[0] is W[t], the new word is W[t+16]
	always_comb begin
		sig0 = shbs_pkg::rotr(win[1], 7) ^ shbs_pkg::rotr(win[1], 18) ^ (win[1] >> 3);
		sig1 = shbs_pkg::rotr(win[14], 17) ^ shbs_pkg::rotr(win[14], 19) ^ (win[14] >> 10);
		w_nxt = sig1 + win[9] + sig0 + win[0];
	end

	// compression round
	always_comb begin
		big1 = shbs_pkg::rotr(v[4], 6) ^ shbs_pkg::rotr(v[4], 11) ^ shbs_pkg::rotr(v[4], 25);
		ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
		big0 = shbs_pkg::rotr(v[0], 2) ^ shbs_pkg::rotr(v[0], 13) ^ shbs_pkg::rotr(v[0], 22);
		maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t1 = v[7] + big1 + ch + kt + win[0];
		t2 = big0 + maj;
		v_nxt[0] = t1 + t2;
		v_nxt[1] = v[0];
		v_nxt[2] = v[1];
		v_nxt[3] = v[2];
		v_nxt[4] = v[3] + t1;
		v_nxt[5] = v[4];
		v_nxt[6] = v[5];
		v_nxt[7] = v[6];
	end

endmodule

`default_nettype wire

@@ design/sha256_byte_stream_hasher_unit.sv @@
// SHA-256 byte stream hasher: top level with block buffer, sequencer and digest output.
//
// Usage: the req channel carries one transaction per message byte (req_type 0)
// or a finish request (req_type 1). The dig channel returns the eight 32-bit
// digest words of a finished message, word 0 first, last_word set on word 7.
// After the digest the hasher is back at its initial values for a new message.
// A byte is taken while the hasher is idle; the byte that fills a 64-byte
// block starts a compression (64 rounds at one round per cycle through the
// single round unit, then one fold of the chain value). A finish compresses
// the padded block, plus a second length-only block when the padding spills
// over, and then presents the digest words one per cycle while dig.ready is
// high. No new byte is taken until the compression of a block is done.
// req.ready is high only while the hasher is idle; while a digest word waits
// on a stalled receiver the hasher holds it and takes no request.
// Reset (arst_n low) loads the initial hash values and clears the byte count.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_unit (
	input  wire          clk,
	input  wire          arst_n,
	shbs_req_if.sink     req,
	shbs_dig_if.source   dig
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	state_t                           state_q;
	logic [5:0]                       round_q;
	logic [shbs_pkg::CountBits-1:0]   count_q;
	shbs_pkg::block_t                 blk_q;
	shbs_pkg::hvec_t                  v_q;
	shbs_pkg::hvec_t                  chain_q;
	logic                             fin_q;
	logic                             two_q;
	logic [2:0]                       idx_q;

	logic [5:0]       pos;
	logic [4:0]       lane_sh;
	logic [63:0]      bit_len;
	shbs_pkg::block_t pad_blk;
	shbs_pkg::block_t len_blk;
	shbs_pkg::hvec_t  v_nxt;
	shbs_pkg::word_t  w_nxt;
	shbs_pkg::hvec_t  folded;

	assign pos = count_q[5:0];
	assign lane_sh = {~pos[1:0], 3'b000};
	assign bit_len = {count_q, 3'b000};

	// final block: 0x80 at the current position, zeros after it, length if it fits
	always_comb begin
		logic [5:0] p;
		pad_blk = blk_q;
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 4; j++) begin
				p = 6'(4 * i + j);
				if (p == pos) begin
					pad_blk[i][31 - 8 * j -: 8] = shbs_pkg::PadByte;
				end else if (p > pos) begin
					pad_blk[i][31 - 8 * j -: 8] = 8'h00;
				end
			end
		end
		if (pos < shbs_pkg::LenBytePos) begin
			pad_blk[14] = bit_len[63:32];
			pad_blk[15] = bit_len[31:0];
		end
	end

	// extra block when the padding spills over
	always_comb begin
		len_blk = '0;
		len_blk[14] = bit_len[63:32];
		len_blk[15] = bit_len[31:0];
	end

	// chain value plus working variables
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			folded[k] = chain_q[k] + v_q[k];
		end
	end

	shbs_round u_round (
		.v     (v_q),
		.win   (blk_q),
		.kt    (shbs_pkg::RoundK[round_q]),
		.v_nxt (v_nxt),
		.w_nxt (w_nxt)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign dig.valid = (state_q == ST_EMIT);
	assign dig.digest_word = chain_q[0];
	assign dig.word_index = idx_q;
	assign dig.last_word = (idx_q == 3'd7);

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			count_q <= '0;
			blk_q <= '0;
			v_q <= '0;
			for (int k = 0; k < 8; k++) begin
				chain_q[k] <= shbs_pkg::InitH[k];
			end
			fin_q <= 1'b0;
			two_q <= 1'b0;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						round_q <= '0;
						v_q <= chain_q;
						if (!req.req_type) begin
							blk_q[pos[5:2]][lane_sh +: 8] <= req.message_byte;
							count_q <= count_q + 1'b1;
							fin_q <= 1'b0;
							two_q <= 1'b0;
							if (pos == shbs_pkg::LastBytePos) begin
								state_q <= ST_ROUND;
							end
						end else begin
							blk_q <= pad_blk;
							fin_q <= 1'b1;
							two_q <= (pos >= shbs_pkg::LenBytePos);
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					v_q <= v_nxt;
					blk_q[0:14] <= blk_q[1:15];
					blk_q[15] <= w_nxt;
					round_q <= round_q + 1'b1;
					if (round_q == shbs_pkg::LastRound) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					chain_q <= folded;
					if (two_q) begin
						// padding spilled: compress the length-only block next
						v_q <= folded;
						blk_q <= len_blk;
						two_q <= 1'b0;
						round_q <= '0;
						state_q <= ST_ROUND;
					end else if (fin_q) begin
						idx_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (dig.ready) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							for (int k = 0; k < 8; k++) begin
								chain_q[k] <= shbs_pkg::InitH[k];
							end
							count_q <= '0;
							fin_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							chain_q[0:6] <= chain_q[1:7];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// no request is taken while a digest word is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && dig.valid))
		else $error("request ready while digest word is valid");

	// the last digest word ends the digest
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid && dig.ready && dig.last_word |=> !dig.valid && req.ready)
		else $error("digest continued after the last word");

	// the round sequence always ends in the fold step
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && round_q == shbs_pkg::LastRound |=> state_q == ST_FOLD)
		else $error("round counter did not end in fold");

	// digest output only follows a finish request
	a_emit_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig.valid) |-> fin_q && dig.word_index == 3'd0)
		else $error("digest started without a finish request");

endmodule

`default_nettype wire
